FILE: sv/iala_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iala_pkg: shared types and constants of the integer ALU
// Operation codes, request/response payloads and the queue entry.
// ----------------------------------------------------------------------------
package iala_pkg;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MULLO  = 3'd2,
      OP_MULFL  = 3'd3,
      OP_DIVSH  = 3'd4,
      OP_DIVLG  = 3'd5,
      OP_CMP    = 3'd6,
      OP_UNDEF  = 3'd7
   } op_type;

   // condition codes
   localparam logic [1:0] CC_POS  = 2'd0;
   localparam logic [1:0] CC_ZERO = 2'd1;
   localparam logic [1:0] CC_NEG  = 2'd2;

   // words written codes
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_BOTH = 2'd2;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 4;
   // divider quotient bits: one quotient bit per cycle
   localparam int DIV_BITS = 32;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        width;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } req_type_type;

   typedef struct packed {
      logic [15:0] res_word0;
      logic [15:0] res_word1;
      logic [1:0]  words_written;
      logic        carry;
      logic [1:0]  cond_code;
      logic        cond_valid;
      logic        fixed_overflow;
      logic        illegal_op;
   } rsp_type;

   // classified operation class
   typedef enum logic [2:0] {
      CLS_ADDSUB = 3'd0,
      CLS_MUL    = 3'd1,
      CLS_DIV    = 3'd2,
      CLS_CMP    = 3'd3,
      CLS_ILL    = 3'd4
   } cls_type;

   // execute states of the back
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2
   } st_type;

   // entry that the front hands to the back
   typedef struct packed {
      cls_type     cls;
      logic [2:0]  op;
      logic        dbl;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } entry_type;

   // condition code of a 16-bit word
   function automatic logic [1:0] sign16(input logic [15:0] v);
      logic [1:0] c;
      if (v == 16'd0) c = CC_ZERO;
      else if (v[15]) c = CC_NEG;
      else c = CC_POS;
      return c;
   endfunction

   // condition code of a 32-bit word
   function automatic logic [1:0] sign32(input logic [31:0] v);
      logic [1:0] c;
      if (v == 32'd0) c = CC_ZERO;
      else if (v[31]) c = CC_NEG;
      else c = CC_POS;
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: sv/isa_integer_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isa_integer_alu_with_flags: 16/32-bit integer ALU with condition flags
// Decode front, short queue, execute back with iterative divider.
//
//   channel   handshake            payload
//   request   start / busy         req_data  (req_type_type)
//   response  rsp_valid strobe     rsp_data  (rsp_type)
//
// Add, subtract, compare and undefined codes: one per cycle while the back
// is idle, result in the cycle after it leaves the queue. Multiplies pass the
// product register and multiply state; divides use the one-bit-per-cycle
// divider. busy rises only when the queue is full. Synchronous reset
// empties the queue and idles the back. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module isa_integer_alu_with_flags import iala_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   logic      q_full, q_empty, push, pop;
   entry_type push_data, head;

   iala_front u_front (
      .start     (start),
      .req_data  (req_data),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   iala_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   iala_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: sv/iala_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iala_front: request decode
// Classifies each accepted request and hands it to the queue.
// ----------------------------------------------------------------------------
module iala_front import iala_pkg::*; (
   input  wire logic         start,
   input  wire req_type_type req_data,
   input  wire logic         q_full,
   output logic              busy,
   output logic              push,
   output entry_type         push_data
);

   op_type op;

   assign busy = q_full;
   assign push = start && !q_full;
   assign op   = op_type'(req_data.req_type);

   // classify the operation
   always_comb begin
      push_data.op   = req_data.req_type;
      push_data.dbl  = req_data.width;
      push_data.op_a = req_data.op_a;
      push_data.op_b = req_data.op_b;
      unique case (op) inside
         OP_ADD, OP_SUB: push_data.cls = CLS_ADDSUB;
         OP_MULLO:       push_data.cls = req_data.width ? CLS_ILL : CLS_MUL;
         OP_MULFL:       push_data.cls = CLS_MUL;
         OP_DIVSH:       push_data.cls = req_data.width ? CLS_ILL : CLS_DIV;
         OP_DIVLG:       push_data.cls = CLS_DIV;
         OP_CMP:         push_data.cls = CLS_CMP;
         default:        push_data.cls = CLS_ILL;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/iala_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iala_queue: short FIFO between decode and execute
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module iala_queue import iala_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/iala_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iala_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iala_divider import iala_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quot,
   output logic [31:0]      rem
);

   localparam int CW = $clog2(DIV_BITS + 1);

   logic [31:0]   q_ff, q_in;
   logic [31:0]   r_ff, r_in;
   logic [31:0]   d_ff, d_in;
   logic          qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [32:0]   trial;
   logic [32:0]   shifted;

   assign shifted = {r_ff, q_ff[31]};
   assign trial   = shifted - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      if (go) begin
         q_in    = dividend[31] ? 32'(-dividend) : dividend;
         d_in    = divisor[31] ? 32'(-divisor) : divisor;
         r_in    = '0;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
         cnt_in  = CW'(DIV_BITS);
         run_in  = 1'b1;
      end else if (run_ff) begin
         // one restoring step
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted[31:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done = done_ff;
   assign quot = qneg_ff ? 32'(-q_ff) : q_ff;
   assign rem  = rneg_ff ? 32'(-r_ff) : r_ff;

endmodule
`default_nettype wire

FILE: sv/iala_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iala_back: execute stage
// Add/sub/compare direct, multiply via product register, divide iteratively.
// ----------------------------------------------------------------------------
module iala_back import iala_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   st_type        st_ff, st_in;
   entry_type     cur_ff;
   logic          rv_ff, rv_in;
   rsp_type       rd_ff, rd_in;
   logic signed [63:0] prod_ff;
   logic          div_go, div_done;
   logic [31:0]   div_quot, div_rem;
   logic          fast;
   logic [32:0]   sum32;
   logic [16:0]   sum16;
   logic [31:0]   aa, bb;
   logic [31:0]   dvd, dvs;
   logic          sub;
   rsp_type       fast_rsp, mul_rsp, div_rsp;
   logic signed [32:0] sa, sb;
   logic          div_ofl;

   assign fast = (head.cls == CLS_ADDSUB) || (head.cls == CLS_CMP) || (head.cls == CLS_ILL);

   // sign-extended operands of the head entry
   always_comb begin
      if (head.dbl) begin
         sa = {head.op_a[31], head.op_a};
         sb = {head.op_b[31], head.op_b};
      end else begin
         sa = 33'(signed'(head.op_a[31:16]));
         sb = 33'(signed'(head.op_b[31:16]));
      end
   end

   // fast operations: add/sub, compare and illegal codes
   always_comb begin
      sub   = (head.op == OP_SUB);
      aa    = head.op_a;
      bb    = head.op_b;
      sum32 = sub ? ({1'b0, aa} - {1'b0, bb}) : ({1'b0, aa} + {1'b0, bb});
      sum16 = sub ? ({1'b0, aa[31:16]} - {1'b0, bb[31:16]})
                  : ({1'b0, aa[31:16]} + {1'b0, bb[31:16]});
      fast_rsp = '0;
      case (head.cls)
         CLS_ADDSUB: begin
            fast_rsp.cond_valid = 1'b1;
            if (head.dbl) begin
               fast_rsp.res_word0 = sum32[31:16];
               fast_rsp.res_word1 = sum32[15:0];
               fast_rsp.words_written = WR_BOTH;
               fast_rsp.carry = sum32[32];
               fast_rsp.cond_code = sign32(sum32[31:0]);
               fast_rsp.fixed_overflow = sub ? ((aa[31] ^ bb[31]) && (aa[31] ^ sum32[31]))
                                             : (!(aa[31] ^ bb[31]) && (bb[31] ^ sum32[31]));
            end else begin
               fast_rsp.res_word0 = sum16[15:0];
               fast_rsp.words_written = WR_ONE;
               fast_rsp.carry = sum16[16];
               fast_rsp.cond_code = sign16(sum16[15:0]);
               fast_rsp.fixed_overflow = sub ? ((aa[31] ^ bb[31]) && (aa[31] ^ sum16[15]))
                                             : (!(aa[31] ^ bb[31]) && (bb[31] ^ sum16[15]));
            end
         end
         CLS_CMP: begin
            fast_rsp.cond_valid = 1'b1;
            if (sa < sb) fast_rsp.cond_code = CC_NEG;
            else if (sa > sb) fast_rsp.cond_code = CC_POS;
            else fast_rsp.cond_code = CC_ZERO;
         end
         default: fast_rsp.illegal_op = 1'b1;
      endcase
   end

   // multiply result from the product register
   always_comb begin
      mul_rsp = '0;
      mul_rsp.cond_valid = 1'b1;
      if (cur_ff.op == OP_MULLO) begin
         mul_rsp.res_word0 = prod_ff[15:0];
         mul_rsp.words_written = WR_ONE;
         mul_rsp.cond_code = sign16(prod_ff[15:0]);
         mul_rsp.fixed_overflow = (prod_ff[63:15] != '0) && (prod_ff[63:15] != '1);
      end else begin
         mul_rsp.res_word0 = prod_ff[31:16];
         mul_rsp.res_word1 = prod_ff[15:0];
         mul_rsp.words_written = WR_BOTH;
         mul_rsp.cond_code = sign32(prod_ff[31:0]);
         mul_rsp.fixed_overflow = cur_ff.dbl &&
            (prod_ff[63:31] != '0) && (prod_ff[63:31] != '1);
      end
   end

   // divider operands
   always_comb begin
      if (head.dbl || head.op == OP_DIVLG) dvd = head.op_a;
      else dvd = {{16{head.op_a[31]}}, head.op_a[31:16]};
      dvs = head.dbl ? head.op_b : {{16{head.op_b[31]}}, head.op_b[31:16]};
   end

   iala_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // divide result
   always_comb begin
      div_rsp = '0;
      if (cur_ff.dbl)
         div_ofl = (cur_ff.op_b == 32'd0) ||
                   (cur_ff.op_a == 32'h8000_0000 && cur_ff.op_b == 32'hFFFF_FFFF);
      else
         div_ofl = (cur_ff.op_b[31:16] == 16'd0) ||
                   (div_quot[31:15] != '0 && div_quot[31:15] != '1);
      if (div_ofl) begin
         div_rsp.fixed_overflow = 1'b1;
      end else begin
         div_rsp.cond_valid = 1'b1;
         div_rsp.words_written = WR_BOTH;
         if (cur_ff.dbl) begin
            div_rsp.res_word0 = div_quot[31:16];
            div_rsp.res_word1 = div_quot[15:0];
            div_rsp.cond_code = sign32(div_quot);
         end else begin
            div_rsp.res_word0 = div_quot[15:0];
            div_rsp.res_word1 = div_rem[15:0];
            div_rsp.cond_code = sign16(div_quot[15:0]);
         end
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (!empty && head.cls == CLS_MUL) st_in = ST_MUL;
            else if (!empty && head.cls == CLS_DIV) st_in = ST_DIV;
         end
         ST_MUL: st_in = ST_IDLE;
         ST_DIV: if (div_done) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      pop    = 1'b0;
      div_go = 1'b0;
      rv_in  = 1'b0;
      rd_in  = rd_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               div_go = (head.cls == CLS_DIV);
               if (fast) begin
                  rv_in = 1'b1;
                  rd_in = fast_rsp;
               end
            end
         end
         ST_MUL: begin
            rv_in = 1'b1;
            rd_in = mul_rsp;
         end
         ST_DIV: begin
            if (div_done) begin
               rv_in = 1'b1;
               rd_in = div_rsp;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
   end

   // entry and product registers
   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (pop) begin
         cur_ff  <= head;
         prod_ff <= 64'(sa * sb);
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

endmodule
`default_nettype wire

FILE: sim/tb_isa_integer_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_isa_integer_alu_with_flags: self-checking bench for the integer ALU
// Directed corner operations, then random single and double length work.
// A queue-fed driver issues requests with random gaps; a monitor compares
// every response against a predicted flag/word set, oldest first.
// ----------------------------------------------------------------------------
module tb_isa_integer_alu_with_flags import iala_pkg::*; ();

   logic         clock;
   logic         reset = 1'b1;
   logic         start;
   logic         busy;
   logic         busy_q;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;

   req_type_type pending_ops[$];
   rsp_type      expected_rsps[$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           gap_left;
   bit           hold_for_drain;
   bit           stimulus_done;

   localparam int CYCLE_LIMIT = 400000;

   isa_integer_alu_with_flags dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [1:0] cc16(input logic [15:0] v);
      if (v == 16'd0) return CC_ZERO;
      return v[15] ? CC_NEG : CC_POS;
   endfunction

   function automatic logic [1:0] cc32(input logic [31:0] v);
      if (v == 32'd0) return CC_ZERO;
      return v[31] ? CC_NEG : CC_POS;
   endfunction

   function automatic logic [1:0] cc_compare(input longint a, input longint b);
      if (a < b) return CC_NEG;
      if (a > b) return CC_POS;
      return CC_ZERO;
   endfunction

   // predict the ALU response of one request
   function automatic rsp_type alu_predict(input req_type_type rq);
      rsp_type     r;
      op_type      op;
      logic [15:0] ua, ub;
      logic [16:0] s17;
      logic [32:0] s33;
      logic [31:0] w32;
      longint      sa, sb, p, dvd, q, rm;
      bit          wr32;
      r = '0;
      op = op_type'(rq.req_type);
      wr32 = 1'b0;
      w32 = '0;
      if (!rq.width) begin
         ua = rq.op_a[31:16];
         ub = rq.op_b[31:16];
         sa = longint'($signed(ua));
         sb = longint'($signed(ub));
         case (op)
            OP_ADD, OP_SUB: begin
               s17 = (op == OP_ADD) ? {1'b0, ua} + {1'b0, ub} : {1'b0, ua} - {1'b0, ub};
               r.carry = s17[16];
               if (op == OP_ADD)
                  r.fixed_overflow = (ua[15] == ub[15]) && (s17[15] != ub[15]);
               else
                  r.fixed_overflow = (ua[15] != ub[15]) && (s17[15] != ua[15]);
               r.res_word0 = s17[15:0];
               r.words_written = WR_ONE;
               r.cond_code = cc16(s17[15:0]);
               r.cond_valid = 1'b1;
            end
            OP_MULLO: begin
               p = sa * sb;
               r.fixed_overflow = (p > 32767 || p < -32768);
               r.res_word0 = p[15:0];
               r.words_written = WR_ONE;
               r.cond_code = cc16(p[15:0]);
               r.cond_valid = 1'b1;
            end
            OP_MULFL: begin
               p = sa * sb;
               {r.res_word0, r.res_word1} = p[31:0];
               r.words_written = WR_BOTH;
               r.cond_code = cc32(p[31:0]);
               r.cond_valid = 1'b1;
            end
            OP_DIVSH, OP_DIVLG: begin
               dvd = (op == OP_DIVSH) ? sa : longint'($signed(rq.op_a));
               if (sb == 0) r.fixed_overflow = 1'b1;
               else begin
                  q = dvd / sb;
                  rm = dvd % sb;
                  if (q > 32767 || q < -32768) r.fixed_overflow = 1'b1;
                  else begin
                     r.res_word0 = q[15:0];
                     r.res_word1 = rm[15:0];
                     r.words_written = WR_BOTH;
                     r.cond_code = cc16(q[15:0]);
                     r.cond_valid = 1'b1;
                  end
               end
            end
            OP_CMP: begin
               r.cond_code = cc_compare(sa, sb);
               r.cond_valid = 1'b1;
            end
            default: r.illegal_op = 1'b1;
         endcase
      end else begin
         sa = longint'($signed(rq.op_a));
         sb = longint'($signed(rq.op_b));
         case (op)
            OP_ADD, OP_SUB: begin
               s33 = (op == OP_ADD) ? {1'b0, rq.op_a} + {1'b0, rq.op_b}
                                    : {1'b0, rq.op_a} - {1'b0, rq.op_b};
               r.carry = s33[32];
               if (op == OP_ADD)
                  r.fixed_overflow = (rq.op_a[31] == rq.op_b[31]) && (s33[31] != rq.op_b[31]);
               else
                  r.fixed_overflow = (rq.op_a[31] != rq.op_b[31]) && (s33[31] != rq.op_a[31]);
               w32 = s33[31:0];
               wr32 = 1'b1;
            end
            OP_MULFL: begin
               p = sa * sb;
               r.fixed_overflow = (p > 64'sh7FFFFFFF || p < -64'sh80000000);
               w32 = p[31:0];
               wr32 = 1'b1;
            end
            OP_DIVLG: begin
               if (sb == 0 || (sa == -64'sh80000000 && sb == -1)) r.fixed_overflow = 1'b1;
               else begin
                  q = sa / sb;
                  w32 = q[31:0];
                  wr32 = 1'b1;
               end
            end
            OP_CMP: begin
               r.cond_code = cc_compare(sa, sb);
               r.cond_valid = 1'b1;
            end
            default: r.illegal_op = 1'b1;
         endcase
         if (wr32) begin
            {r.res_word0, r.res_word1} = w32;
            r.words_written = WR_BOTH;
            r.cond_code = cc32(w32);
            r.cond_valid = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // operand values biased toward edge values
   function automatic logic [31:0] pick_operand();
      logic [15:0] edges[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000,
                                16'h7FFF, 16'h8001, 16'h0002, 16'hFFFE};
      case ($urandom_range(0, 5))
         0: return {edges[$urandom_range(0, 7)], edges[$urandom_range(0, 7)]};
         1: return {16'($urandom_range(0, 15) - 8), 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic push_op(input op_type op, input bit w, input logic [31:0] a,
                          input logic [31:0] b);
      req_type_type rq;
      rq.req_type = op;
      rq.width = w;
      rq.op_a = a;
      rq.op_b = b;
      pending_ops.push_back(rq);
   endtask

   // stimulus
   initial begin
      req_type_type rq;
      op_type       op;
      longint       qd, dv;
      stimulus_done = 1'b0;
      // directed corners
      push_op(OP_ADD, 1'b0, 32'h7FFF_0000, 32'h0001_0000);
      push_op(OP_ADD, 1'b0, 32'hFFFF_1234, 32'h0001_5678);
      push_op(OP_SUB, 1'b0, 32'h8000_0000, 32'h0001_0000);
      push_op(OP_SUB, 1'b0, 32'h0000_0000, 32'h0001_0000);
      push_op(OP_MULLO, 1'b0, 32'h0100_0000, 32'h0100_0000);
      push_op(OP_MULLO, 1'b0, 32'hFFFF_0000, 32'h8000_0000);
      push_op(OP_MULFL, 1'b0, 32'h8000_0000, 32'h8000_0000);
      push_op(OP_DIVSH, 1'b0, 32'h8000_0000, 32'hFFFF_0000);
      push_op(OP_DIVSH, 1'b0, 32'hFFF9_0000, 32'h0002_0000);
      push_op(OP_DIVSH, 1'b0, 32'h1234_0000, 32'h0000_0000);
      push_op(OP_DIVLG, 1'b0, 32'h0001_0000, 32'h0001_0000);
      push_op(OP_DIVLG, 1'b0, 32'hFFFF_FFF9, 32'h0002_0000);
      push_op(OP_CMP, 1'b0, 32'h8000_0000, 32'h7FFF_0000);
      push_op(OP_CMP, 1'b0, 32'h1234_0000, 32'h1234_FFFF);
      push_op(OP_UNDEF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(OP_ADD, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001);
      push_op(OP_SUB, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      push_op(OP_MULLO, 1'b1, 32'h1, 32'h1);
      push_op(OP_MULFL, 1'b1, 32'h0001_0000, 32'h0001_0000);
      push_op(OP_MULFL, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000);
      push_op(OP_DIVSH, 1'b1, 32'h10, 32'h2);
      push_op(OP_DIVLG, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
      push_op(OP_DIVLG, 1'b1, 32'hFFFF_FFF9, 32'h0000_0002);
      push_op(OP_DIVLG, 1'b1, 32'h1234_5678, 32'h0);
      push_op(OP_CMP, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      push_op(OP_UNDEF, 1'b1, 32'h0, 32'h0);
      // random work; single-length long divides often well-conditioned
      repeat (630) begin
         op = op_type'($urandom_range(0, 7));
         rq.req_type = op;
         rq.width = 1'($urandom_range(0, 1));
         rq.op_a = pick_operand();
         rq.op_b = pick_operand();
         if (op == OP_DIVLG && !rq.width && $urandom_range(0, 2) != 0) begin
            dv = longint'($signed(rq.op_b[31:16]));
            qd = longint'($signed(16'($urandom)));
            if (dv == 0) dv = 3;
            rq.op_b[31:16] = dv[15:0];
            qd = qd * dv + (dv > 0 ? longint'($urandom_range(0, 2)) % dv : 0);
            rq.op_a = qd[31:0];
         end
         pending_ops.push_back(rq);
      end
      stimulus_done = 1'b1;
   end

   // driver
   always @(negedge clock) begin
      if (reset || cycle_count < 5) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (start && !busy_q) begin
         // previous transfer went through at the last edge
         if (gap_left == 0 && pending_ops.size() > 0 && !hold_for_drain
             && $urandom_range(0, 3) != 0) begin
            req_data <= pending_ops.pop_front();
         end else begin
            start <= 1'b0;
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                    : $urandom_range(0, 3);
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_ops.size() > 0 && !hold_for_drain) begin
            start <= 1'b1;
            req_data <= pending_ops.pop_front();
         end
      end
   end

   // busy as seen at the last rising edge
   always @(posedge clock) busy_q <= busy;

   // pause once mid-run until everything has drained
   always @(posedge clock) begin
      if (reset) hold_for_drain <= 1'b0;
      else if (pending_ops.size() == 300 && !hold_for_drain) hold_for_drain <= 1'b1;
      else if (hold_for_drain && expected_rsps.size() == 0 && !start)
         hold_for_drain <= 1'b0;
   end

   // monitor: record accepted requests, check responses
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == 4) reset <= 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 32'd1, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.res_word0 != want.res_word0)
                  report_mismatch("res_word0", 32'(rsp_data.res_word0),
                                  32'(want.res_word0));
               if (rsp_data.res_word1 != want.res_word1)
                  report_mismatch("res_word1", 32'(rsp_data.res_word1),
                                  32'(want.res_word1));
               if (rsp_data.words_written != want.words_written)
                  report_mismatch("words_written", 32'(rsp_data.words_written),
                                  32'(want.words_written));
               if (rsp_data.carry != want.carry)
                  report_mismatch("carry", 32'(rsp_data.carry), 32'(want.carry));
               if (rsp_data.cond_code != want.cond_code)
                  report_mismatch("cond_code", 32'(rsp_data.cond_code),
                                  32'(want.cond_code));
               if (rsp_data.cond_valid != want.cond_valid)
                  report_mismatch("cond_valid", 32'(rsp_data.cond_valid),
                                  32'(want.cond_valid));
               if (rsp_data.fixed_overflow != want.fixed_overflow)
                  report_mismatch("fixed_overflow", 32'(rsp_data.fixed_overflow),
                                  32'(want.fixed_overflow));
               if (rsp_data.illegal_op != want.illegal_op)
                  report_mismatch("illegal_op", 32'(rsp_data.illegal_op),
                                  32'(want.illegal_op));
            end
         end
         if (start && !busy) expected_rsps.push_back(alu_predict(req_data));
      end
   end

   // end of run
   initial begin
      do @(posedge clock);
      while (!((stimulus_done && pending_ops.size() == 0 && !start
                && expected_rsps.size() == 0 && cycle_count > 10)
               || cycle_count >= CYCLE_LIMIT));
      if (cycle_count < CYCLE_LIMIT) begin
         repeat (50) @(posedge clock);
         if (mismatches == 0 && expected_rsps.size() == 0)
            $display("tb_isa_integer_alu_with_flags passed");
         else
            $display("tb_isa_integer_alu_with_flags failed");
      end else begin
         $display("timeout at cycle %0d", cycle_count);
         $display("tb_isa_integer_alu_with_flags failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/iala_pkg.sv
sv/iala_front.sv
sv/iala_queue.sv
sv/iala_divider.sv
sv/iala_back.sv
sv/isa_integer_alu_with_flags.sv
sim/tb_isa_integer_alu_with_flags.sv
